// File: src/okst_pkg.sv
// Package for the owned key slot table: table size, request and status codes,
// request/response payload structs and the controller/datapath interface structs.
// No dependencies.
package okst_pkg;

    // Number of slots, slot 0 included (slot 0 is reserved and never filled).
    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_SLOTS - 1);

    // Widths fixed by the request and response fields.
    localparam int REQ_W    = 3;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 4;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_CREATE       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_OWNER_OF_KEY = 3'd1;
    localparam logic [REQ_W-1:0] REQ_KEY_OF_OWNER = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CHECK_OWNER  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_BY_OWNER = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DEL_BY_KEY   = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_OWNED     = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [KEY_W-1:0] room_key;
        logic [KEY_W-1:0] client_ident;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot_index;
        logic [KEY_W-1:0]    found_value;
        logic [CNT_W-1:0]    cleared_count;
    } t_rsp;

    // One stored slot: key and owner.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] owner;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch a new request and restart the scan
        logic step;    // advance the scan by one slot
        logic finish;  // commit any create write and load the response
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // last slot is being evaluated this cycle
        logic out_free;   // response register can take a new response
    } t_dp_stat;

endpackage

// File: src/owned_key_slot_table_core.sv
// Owned key slot table: a request is accepted, slots 1 to TABLE_SLOTS-1 are scanned
// in order through a registered memory read, and one response is returned.
// A new request is taken only after the previous one has been committed to the
// response register; the scan itself evaluates one slot per cycle.
// Reset (synchronous, active low) clears every slot's valid flag and empties the
// response register; the table is usable as soon as reset is released.
module owned_key_slot_table_core
    import okst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    // The controller sequences each request through three phases: it takes the
    // request while idle, steps the datapath through the slot scan, and then waits
    // until the response register is free before committing the result. A response
    // that is still waiting downstream does not block the next request from being
    // accepted; it only delays that request's final commit.
    t_ctl_cmd cmd;
    t_dp_stat stat;

    okst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // The datapath holds the slot memory (key and owner per slot), the per-slot
    // valid flags, the first-match and first-free trackers, and the response
    // register. Deletes clear valid flags during the scan; a create writes its slot
    // only at commit, once the whole table has been checked for an owned key.
    okst_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

endmodule

// File: src/okst_ctrl.sv
// Controller of the owned key slot table: idle / scan / done sequencing.
// Depends on okst_pkg.
module okst_ctrl
    import okst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.scan_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall      = 1'b1;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
            end
            ST_DONE: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: src/okst_datapath.sv
// Datapath of the owned key slot table: slot memory, valid flags, scan
// evaluation, match accumulation and the response register. Depends on okst_pkg.
module okst_datapath
    import okst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_req     i_req,
    input  t_ctl_cmd i_cmd,
    output t_dp_stat o_stat,
    output logic     o_valid,
    input  logic     i_stall,
    output t_rsp     o_rsp
);

    // Key and owner storage; meaningful only where the valid flag is set.
    t_entry r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_valid;

    t_req              r_req;
    logic [SLOT_W-1:0] r_addr;
    logic              r_issue;
    logic              r_rd_pend;
    logic [SLOT_W-1:0] r_rd_idx;
    t_entry            r_rd_ent;

    // Accumulated scan results.
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_idx;
    logic [KEY_W-1:0]  r_hit_val;
    logic              r_free;
    logic [SLOT_W-1:0] r_free_idx;
    logic [CNT_W-1:0]  r_cnt;

    logic              r_out_vld;
    t_rsp              r_out;

    logic             ev;
    logic             slot_v;
    logic             key_eq;
    logic             own_eq;
    logic             match;
    logic [KEY_W-1:0] match_val;
    logic             first;
    logic             do_clear;
    logic             create_ok;
    t_rsp             rsp;

    // Evaluation of the slot whose contents arrived from memory this cycle.
    always_comb begin
        ev        = i_cmd.step && r_rd_pend;
        slot_v    = r_valid[r_rd_idx];
        key_eq    = (r_rd_ent.key == r_req.room_key);
        own_eq    = (r_rd_ent.owner == r_req.client_ident);
        match     = 1'b0;
        match_val = r_rd_ent.owner;
        unique case (r_req.req_type)
            REQ_CREATE, REQ_OWNER_OF_KEY: begin
                match     = slot_v && key_eq;
                match_val = r_rd_ent.owner;
            end
            REQ_KEY_OF_OWNER: begin
                match     = slot_v && own_eq;
                match_val = r_rd_ent.key;
            end
            REQ_CHECK_OWNER: begin
                match     = slot_v && own_eq && key_eq;
                match_val = r_rd_ent.key;
            end
            REQ_DEL_BY_OWNER: begin
                match = slot_v && own_eq && (r_req.client_ident != '0);
            end
            REQ_DEL_BY_KEY: begin
                match = slot_v && key_eq;
            end
            default: match = 1'b0;
        endcase
        first    = ev && match && !r_hit;
        do_clear = ev && (((r_req.req_type == REQ_DEL_BY_OWNER) && match) ||
                          ((r_req.req_type == REQ_DEL_BY_KEY) && first));
    end

    // Response built from the accumulated scan results.
    always_comb begin
        create_ok         = 1'b0;
        rsp.status        = STS_NOT_FOUND;
        rsp.slot_index    = '0;
        rsp.found_value   = '0;
        rsp.cleared_count = '0;
        unique case (r_req.req_type)
            REQ_CREATE: begin
                if (r_hit && (r_hit_val != '0)) begin
                    rsp.status = STS_OWNED;
                end else if (r_free) begin
                    create_ok      = 1'b1;
                    rsp.status     = STS_OK;
                    rsp.slot_index = IDX_W'(r_free_idx);
                end else begin
                    rsp.status = STS_FULL;
                end
            end
            REQ_OWNER_OF_KEY, REQ_KEY_OF_OWNER, REQ_CHECK_OWNER: begin
                if (r_hit) begin
                    rsp.status      = STS_OK;
                    rsp.slot_index  = IDX_W'(r_hit_idx);
                    rsp.found_value = r_hit_val;
                end
            end
            REQ_DEL_BY_OWNER, REQ_DEL_BY_KEY: begin
                if (r_hit) begin
                    rsp.status        = STS_OK;
                    rsp.slot_index    = IDX_W'(r_hit_idx);
                    rsp.cleared_count = r_cnt;
                end
            end
            default: rsp.status = STS_NOT_FOUND;
        endcase
    end

    // Scan address sequencing and registered memory read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= FIRST_SLOT;
            r_issue   <= 1'b0;
            r_rd_pend <= 1'b0;
        end else if (i_cmd.load) begin
            r_addr    <= FIRST_SLOT;
            r_issue   <= 1'b1;
            r_rd_pend <= 1'b0;
        end else if (i_cmd.step) begin
            r_rd_pend <= r_issue;
            if (r_issue) begin
                if (r_addr == LAST_SLOT) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.step && r_issue) begin
            r_rd_ent <= r_mem[r_addr];
            r_rd_idx <= r_addr;
        end
        if (i_cmd.finish && create_ok) begin
            r_mem[r_free_idx] <= '{key: r_req.room_key, owner: r_req.client_ident};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (do_clear) begin
            r_valid[r_rd_idx] <= 1'b0;
        end else if (i_cmd.finish && create_ok) begin
            r_valid[r_free_idx] <= 1'b1;
        end
    end

    // Match accumulators.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (first) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
                r_hit_val <= match_val;
            end
            if (ev && !slot_v && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if (do_clear && (r_cnt != CNT_MAX)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= rsp;
        end
    end

    assign o_stat.scan_done = ev && (r_rd_idx == LAST_SLOT);
    assign o_stat.out_free  = !r_out_vld || !i_stall;
    assign o_valid          = r_out_vld;
    assign o_rsp            = r_out;

    a_slot0_never_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[0])
        else $error("reserved slot 0 became valid");

    a_read_not_slot0 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_rd_idx != '0))
        else $error("scan evaluated the reserved slot");

    a_issue_addr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue |-> (r_addr != '0))
        else $error("scan address points at the reserved slot");

    a_finish_gives_rsp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_vld)
        else $error("finished request produced no response");

endmodule

// File: dv/okst_answer_checker.sv
// Answer checker for the owned key slot table: keeps its own copy of the slots,
// predicts the answer to every accepted request and compares it with the block's answers.
// Depends on okst_pkg for the request, answer and status types.
`timescale 1ns / 100ps

module okst_answer_checker
    import okst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_stall,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_stall,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_refused,
    output int   o_full,
    output int   o_missed
);

    logic             slot_used   [TABLE_SLOTS];
    logic [KEY_W-1:0] slot_room   [TABLE_SLOTS];
    logic [KEY_W-1:0] slot_client [TABLE_SLOTS];

    t_rsp awaited_answers [$];
    t_rsp oldest;
    t_rsp predicted;
    int   fails;
    int   checked;
    int   refused;
    int   full;
    int   missed;

    // First occupied slot holding the key, or 0 when there is none.
    function automatic int first_slot_with_key(input logic [KEY_W-1:0] key);
        for (int s = 1; s < TABLE_SLOTS; s++) begin
            if (slot_used[s] && slot_room[s] == key) begin
                return s;
            end
        end
        return 0;
    endfunction

    task automatic clear_table_slot(input int s);
        slot_used[s]   = 1'b0;
        slot_room[s]   = '0;
        slot_client[s] = '0;
    endtask

    // Applies one request to the local table and works out the answer it earns.
    task automatic predict_answer(input t_req r, output t_rsp a);
        int hit;
        a        = '0;
        a.status = STS_NOT_FOUND;
        case (r.req_type)
            REQ_CREATE: begin
                hit = first_slot_with_key(r.room_key);
                if (hit != 0 && slot_client[hit] != '0) begin
                    a.status = STS_OWNED;
                end else begin
                    a.status = STS_FULL;
                    for (int s = 1; s < TABLE_SLOTS; s++) begin
                        if (!slot_used[s]) begin
                            slot_used[s]   = 1'b1;
                            slot_room[s]   = r.room_key;
                            slot_client[s] = r.client_ident;
                            a.status       = STS_OK;
                            a.slot_index   = IDX_W'(s);
                            break;
                        end
                    end
                end
            end
            REQ_OWNER_OF_KEY: begin
                hit = first_slot_with_key(r.room_key);
                if (hit != 0) begin
                    a.status      = STS_OK;
                    a.slot_index  = IDX_W'(hit);
                    a.found_value = slot_client[hit];
                end
            end
            REQ_KEY_OF_OWNER, REQ_CHECK_OWNER: begin
                for (int s = 1; s < TABLE_SLOTS; s++) begin
                    if (slot_used[s] && slot_client[s] == r.client_ident &&
                        (r.req_type == REQ_KEY_OF_OWNER || slot_room[s] == r.room_key)) begin
                        a.status      = STS_OK;
                        a.slot_index  = IDX_W'(s);
                        a.found_value = slot_room[s];
                        break;
                    end
                end
            end
            REQ_DEL_BY_OWNER: begin
                // An owner of zero stands for nobody, so nothing is cleared.
                if (r.client_ident != '0) begin
                    for (int s = 1; s < TABLE_SLOTS; s++) begin
                        if (slot_used[s] && slot_client[s] == r.client_ident) begin
                            if (a.cleared_count == '0) begin
                                a.slot_index = IDX_W'(s);
                            end
                            if (a.cleared_count != CNT_MAX) begin
                                a.cleared_count = a.cleared_count + CNT_W'(1);
                            end
                            clear_table_slot(s);
                            a.status = STS_OK;
                        end
                    end
                end
            end
            REQ_DEL_BY_KEY: begin
                hit = first_slot_with_key(r.room_key);
                if (hit != 0) begin
                    clear_table_slot(hit);
                    a.status        = STS_OK;
                    a.slot_index    = IDX_W'(hit);
                    a.cleared_count = CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                clear_table_slot(s);
            end
            awaited_answers.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (awaited_answers.size() == 0) begin
                    $error("answer 0x%0h arrived with no request waiting for one", i_rsp);
                    fails++;
                end else begin
                    oldest = awaited_answers.pop_front();
                    check_field("status", KEY_W'(oldest.status), KEY_W'(i_rsp.status));
                    check_field("slot_index", KEY_W'(oldest.slot_index),
                                KEY_W'(i_rsp.slot_index));
                    check_field("found_value", oldest.found_value, i_rsp.found_value);
                    check_field("cleared_count", KEY_W'(oldest.cleared_count),
                                KEY_W'(i_rsp.cleared_count));
                    checked++;
                    case (oldest.status)
                        STS_OWNED:     refused++;
                        STS_FULL:      full++;
                        STS_NOT_FOUND: missed++;
                        default: begin
                        end
                    endcase
                end
            end
            if (i_req_valid && !i_req_stall) begin
                predict_answer(i_req, predicted);
                awaited_answers.push_back(predicted);
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_answers.size();
        o_checked    <= checked;
        o_refused    <= refused;
        o_full       <= full;
        o_missed     <= missed;
    end

endmodule

// File: dv/owned_key_slot_table_core_tb.sv
// Testbench top for owned_key_slot_table_core: drives directed and random requests
// with random idling on both sides and gives the verdict from the answer checker's count.
// Depends on okst_pkg, okst_answer_checker and the block itself.
`timescale 1ns / 100ps

module owned_key_slot_table_core_tb;
    import okst_pkg::*;

    // Generous ceiling on the run length for roughly 700 requests, allowing for the
    // longest sender gaps and answer stalls several times over.
    localparam int RUN_LIMIT = 200_000;

    // Request codes the block does not use; they must be answered as not found.
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    localparam logic [KEY_W-1:0] FLOOD_OWNER = {KEY_W{1'b1}};
    localparam int KEY_POOL   = 12;
    localparam int OWNER_POOL = 5;
    localparam int RECENT     = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_req i_req   = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_rsp o_rsp;

    int fail_count;
    int answers_pending;
    int answers_checked;
    int answers_refused;
    int answers_full;
    int answers_missed;

    // Percentages of requests before which the sender holds off, and of cycles in which the receiver stalls.
    int tx_idle_pct   = 7;
    int rx_idle_pct   = 7;
    // Share of random keys drawn fresh rather than from the small pool.
    int key_fresh_pct = 15;

    int requests_sent;
    int cycle_count;

    // Small pools of keys and owners so that random requests keep hitting
    // entries already in the table; the first two of each are all zeros and all ones.
    bit [KEY_W-1:0] key_pool      [KEY_POOL];
    bit [KEY_W-1:0] owner_pool    [OWNER_POOL];
    // Pairs from recent create requests, used to aim ownership checks at likely entries.
    bit [KEY_W-1:0] recent_room   [RECENT];
    bit [KEY_W-1:0] recent_client [RECENT];
    int             recent_head;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    owned_key_slot_table_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    okst_answer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_req        (i_req),
        .i_rsp_valid  (o_valid),
        .i_rsp_stall  (i_stall),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (answers_pending),
        .o_checked    (answers_checked),
        .o_refused    (answers_refused),
        .o_full       (answers_full),
        .o_missed     (answers_missed)
    );

    // The answer side stalls in cycles drawn at random, each on its own; the rate is zero during
    // the stretch with no idling.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    function automatic t_req make_req(input logic [REQ_W-1:0] kind,
                                      input logic [KEY_W-1:0] key,
                                      input logic [KEY_W-1:0] who);
        t_req r;
        r.req_type     = kind;
        r.room_key     = key;
        r.client_ident = who;
        return r;
    endfunction

    // Offers one request and returns at the edge where the block takes it.
    // Valid stays high from one request to the next unless the sender decides
    // to hold off, so back-to-back requests are offered as well.
    task automatic send_request(input t_req r);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
        if (r.req_type == REQ_CREATE) begin
            recent_room[recent_head]   = r.room_key;
            recent_client[recent_head] = r.client_ident;
            recent_head                = (recent_head + 1) % RECENT;
        end
    endtask

    // Drops valid and waits until every request sent so far has been answered.
    // The first edge lets the checker's count take in the last accepted request.
    task automatic wait_for_answers();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (answers_pending != 0) @(posedge i_clk);
    endtask

    // Random traffic: creates dominate so that the table keeps filling up,
    // deletes of both kinds empty it again, and lookups hit pooled keys and owners.
    function automatic t_req random_request();
        t_req r;
        int   roll;
        int   pick;
        roll = $urandom_range(99);
        pick = $urandom_range(RECENT - 1);
        r.room_key = ($urandom_range(99) < key_fresh_pct) ? $urandom
                                                          : key_pool[$urandom_range(KEY_POOL - 1)];
        r.client_ident = ($urandom_range(99) < 15) ? $urandom
                                                   : owner_pool[$urandom_range(OWNER_POOL - 1)];
        if (roll < 34) begin
            r.req_type = REQ_CREATE;
        end else if (roll < 46) begin
            r.req_type = REQ_OWNER_OF_KEY;
        end else if (roll < 56) begin
            r.req_type = REQ_KEY_OF_OWNER;
        end else if (roll < 68) begin
            r.req_type = REQ_CHECK_OWNER;
        end else if (roll < 80) begin
            r.req_type = REQ_DEL_BY_OWNER;
        end else if (roll < 96) begin
            r.req_type = REQ_DEL_BY_KEY;
        end else begin
            r.req_type = roll[0] ? REQ_SPARE_LO : REQ_SPARE_HI;
        end
        // A check against a pair that really was created is far more telling
        // than one against an arbitrary key and owner.
        if (r.req_type == REQ_CHECK_OWNER && $urandom_range(99) < 60) begin
            r.room_key     = recent_room[pick];
            r.client_ident = recent_client[pick];
        end
        return r;
    endfunction

    task automatic run_directed();
        // Empty table: a lookup and a delete that both miss.
        send_request(make_req(REQ_OWNER_OF_KEY, '0, '0));
        send_request(make_req(REQ_DEL_BY_KEY, FLOOD_OWNER, FLOOD_OWNER));
        // The two unused request codes, with every owner bit set.
        send_request(make_req(REQ_SPARE_LO, FLOOD_OWNER, FLOOD_OWNER));
        send_request(make_req(REQ_SPARE_HI, '0, FLOOD_OWNER));
        // Fill every usable slot under one owner; the last key is all ones.
        for (int s = 1; s < TABLE_SLOTS; s++) begin
            send_request(make_req(REQ_CREATE, FLOOD_OWNER - KEY_W'(TABLE_SLOTS - 1 - s),
                                  FLOOD_OWNER));
        end
        // The key is owned, so the create is refused before fullness is looked at.
        send_request(make_req(REQ_CREATE, FLOOD_OWNER, KEY_W'(1)));
        // A new key finds no free slot.
        send_request(make_req(REQ_CREATE, KEY_W'(32'h0000_1234), KEY_W'(7)));
        send_request(make_req(REQ_CHECK_OWNER, FLOOD_OWNER, FLOOD_OWNER));
        // Clearing the whole table under one owner takes the count to its ceiling.
        send_request(make_req(REQ_DEL_BY_OWNER, '0, FLOOD_OWNER));
        // A slot owned by nobody: deleting owner zero must leave it alone, and a
        // second create of the same key is allowed because the first has no owner.
        send_request(make_req(REQ_CREATE, '0, '0));
        send_request(make_req(REQ_DEL_BY_OWNER, '0, '0));
        send_request(make_req(REQ_CREATE, '0, FLOOD_OWNER));
        send_request(make_req(REQ_OWNER_OF_KEY, '0, FLOOD_OWNER));
        send_request(make_req(REQ_KEY_OF_OWNER, FLOOD_OWNER, '0));
        send_request(make_req(REQ_DEL_BY_KEY, '0, '0));
    endtask

    // Watchdog: a run that has not finished by the limit has hung somewhere.
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("owned_key_slot_table_core regression: fail");
        $finish;
    end

    initial begin
        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i] = $urandom;
        end
        for (int i = 0; i < OWNER_POOL; i++) begin
            owner_pool[i] = $urandom;
        end
        key_pool[0]   = '0;
        key_pool[1]   = '1;
        owner_pool[0] = '0;
        owner_pool[1] = '1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        wait_for_answers();

        // First random phase with idling on both sides.
        for (int n = 0; n < 250; n++) begin
            send_request(random_request());
        end

        // The sender holds off until the table has answered everything, then
        // both sides run flat out for a long stretch.
        wait_for_answers();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int n = 0; n < 150; n++) begin
            send_request(random_request());
        end

        // Last phase: idling again, and more fresh keys so that the table fills.
        tx_idle_pct   = 7;
        rx_idle_pct   = 7;
        key_fresh_pct = 45;
        for (int n = 0; n < 250; n++) begin
            send_request(random_request());
        end

        // Let any stray answer show itself before the verdict.
        wait_for_answers();
        repeat (TABLE_SLOTS + 4) @(posedge i_clk);

        $display("Sent %0d requests over %0d cycles: directed table fill, owner-zero and spare-code cases, then random traffic.",
                 requests_sent, cycle_count);
        $display("Checked %0d answers, of which %0d refused as owned, %0d table full, %0d not found.",
                 answers_checked, answers_refused, answers_full, answers_missed);
        if (fail_count == 0) begin
            $display("owned_key_slot_table_core regression: pass");
        end else begin
            $display("owned_key_slot_table_core regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
src/okst_pkg.sv
src/okst_ctrl.sv
src/okst_datapath.sv
src/owned_key_slot_table_core.sv
dv/okst_answer_checker.sv
dv/owned_key_slot_table_core_tb.sv
